>>> rtl/rcb_pkg.sv
// ----------------------------------------------------------------------------
// rcb_pkg
// Shared types and constants for the replicated counter broadcaster.
// ----------------------------------------------------------------------------
`default_nettype none

package rcb_pkg;

  localparam int CFG_DATA_W = 48;
  localparam int MAX_OUT    = 7;

  localparam logic [3:0]  NODE_COUNT_RST = 4'd2;
  localparam logic [30:0] FAIL_AT_OP_RST = 31'h7fff_ffff;

  typedef enum logic [2:0] {
    CFG_OP_TOTAL        = 3'd0,
    CFG_NODE_COUNT      = 3'd1,
    CFG_BOARD_ID        = 3'd2,
    CFG_FAIL_AT_OP      = 3'd3,
    CFG_FAILING_NODE    = 3'd4,
    CFG_LOCAL_ADDRESS   = 3'd5,
    CFG_REMOTE_BASE     = 3'd6,
    CFG_TRANSFER_LENGTH = 3'd7
  } cfg_index_t;

  typedef enum logic {
    KIND_QUERY = 1'b0,
    KIND_WRITE = 1'b1
  } kind_t;

  typedef struct packed {
    logic [30:0] op_total;
    logic [3:0]  node_count;
    logic [2:0]  board_id;
    logic [30:0] fail_at_op;
    logic [2:0]  failing_node;
    logic [47:0] local_address;
    logic [47:0] remote_base;
    logic [31:0] transfer_length;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [23:0] queue_number;
    logic [47:0] local_addr_out;
    logic [47:0] remote_addr_out;
    logic [31:0] length_out;
    logic [63:0] value;
    logic        last;
  } result_t;

  typedef struct packed {
    logic accept;      // op taken from the input channel this cycle
    logic load_query;  // put the query response in the output register
    logic start_scan;  // begin walking the node list
    logic advance;     // step to the next node index
    logic emit;        // put a write descriptor in the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic skip;        // op dropped: halted or op budget used up
    logic halt_now;    // op hits the injected failure of this board
    logic is_query;
    logic out_free;
    logic scan_done;
    logic emit_now;    // current node is a live peer
    logic halted;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/rcb_op_if.sv
// ----------------------------------------------------------------------------
// rcb_op_if
// Input channel: one counter operation per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcb_op_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] amount;

  modport source (output valid, output amount, input ready);
  modport sink   (input valid, input amount, output ready);
endinterface

`default_nettype wire

>>> rtl/rcb_result_if.sv
// ----------------------------------------------------------------------------
// rcb_result_if
// Output channel: query responses and remote-write descriptors.
// ----------------------------------------------------------------------------
`default_nettype none

interface rcb_result_if;
  logic             valid;
  logic             ready;
  rcb_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/replicated_counter_broadcaster.sv
// ----------------------------------------------------------------------------
// replicated_counter_broadcaster
// Replicated counter: applies ops and broadcasts remote-write descriptors.
// ----------------------------------------------------------------------------
// Usage:
//   ops carries one signed amount per item. Zero is a query: one result with
//   the 64-bit counter. Nonzero is added to the counter and gives one write
//   descriptor per live peer, at most seven, the final one flagged last.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Timing:
//   An op is taken from IDLE. A query moves to QUERY, which loads the result
//   into the output register once that register is free. An increment walks
//   the node list one index per cycle while no live peer waits on a busy
//   output register, holding the input off until the walk ends; a descriptor
//   leaves the walk on each live peer, at most seven. Dropped ops (halted or
//   budget used) leave the sequencer in IDLE.
// Reset:
//   rst clears the counter, op count, failure mask and halt flag and loads
//   the register defaults. Results are held in the output register while
//   results.ready is low; the walk waits on that register, and a new op is
//   taken as soon as the previous walk ends.
// ----------------------------------------------------------------------------
`default_nettype none

module replicated_counter_broadcaster #(
  parameter int MAX_NODES = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [2:0]                     cfg_index,
  input  wire logic [rcb_pkg::CFG_DATA_W-1:0] cfg_data,
  rcb_op_if.sink                              ops,
  rcb_result_if.source                        results
);

  rcb_pkg::cfg_t       cfg;
  rcb_pkg::ctrl_cmd_t  cmd;
  rcb_pkg::dp_status_t status;
  rcb_pkg::result_t    result;
  logic                result_valid;
  logic                op_ready;

  rcb_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rcb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .op_valid (ops.valid),
    .op_ready (op_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rcb_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .amount       (ops.amount),
    .cmd          (cmd),
    .status       (status),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (results.ready)
  );

  assign ops.ready     = op_ready;
  assign results.valid = result_valid;
  assign results.data  = result;

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.load_query) |-> (!result_valid || results.ready))
    else $error("output register loaded while a result is pending");

  // once halted, no op starts any output
  a_halted_quiet: assert property (@(posedge clk) disable iff (rst)
    status.halted |-> (!cmd.start_scan && !cmd.load_query))
    else $error("halted block started an op");

  // a dropped op leaves the input open on the next cycle
  a_drop_fast: assert property (@(posedge clk) disable iff (rst)
    (ops.valid && op_ready && status.skip) |=> op_ready)
    else $error("dropped op did not return to idle");

  // an emitted descriptor is always a write
  a_emit_kind: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (result_valid && result.kind == rcb_pkg::KIND_WRITE))
    else $error("write descriptor not presented");

endmodule

`default_nettype wire

>>> rtl/rcb_regs.sv
// ----------------------------------------------------------------------------
// rcb_regs
// Configuration register file, write only.
// ----------------------------------------------------------------------------
`default_nettype none

module rcb_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [2:0]                     cfg_index,
  input  wire logic [rcb_pkg::CFG_DATA_W-1:0] cfg_data,
  output rcb_pkg::cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.op_total        <= '0;
      cfg.node_count      <= rcb_pkg::NODE_COUNT_RST;
      cfg.board_id        <= '0;
      cfg.fail_at_op      <= rcb_pkg::FAIL_AT_OP_RST;
      cfg.failing_node    <= '0;
      cfg.local_address   <= '0;
      cfg.remote_base     <= '0;
      cfg.transfer_length <= '0;
    end else if (cfg_we) begin
      unique case (rcb_pkg::cfg_index_t'(cfg_index))
        rcb_pkg::CFG_OP_TOTAL:        cfg.op_total        <= cfg_data[30:0];
        rcb_pkg::CFG_NODE_COUNT:      cfg.node_count      <= cfg_data[3:0];
        rcb_pkg::CFG_BOARD_ID:        cfg.board_id        <= cfg_data[2:0];
        rcb_pkg::CFG_FAIL_AT_OP:      cfg.fail_at_op      <= cfg_data[30:0];
        rcb_pkg::CFG_FAILING_NODE:    cfg.failing_node    <= cfg_data[2:0];
        rcb_pkg::CFG_LOCAL_ADDRESS:   cfg.local_address   <= cfg_data[47:0];
        rcb_pkg::CFG_REMOTE_BASE:     cfg.remote_base     <= cfg_data[47:0];
        rcb_pkg::CFG_TRANSFER_LENGTH: cfg.transfer_length <= cfg_data[31:0];
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/rcb_ctrl.sv
// ----------------------------------------------------------------------------
// rcb_ctrl
// Sequencer: takes an op, then issues the query response or walks the nodes.
// ----------------------------------------------------------------------------
`default_nettype none

module rcb_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                op_valid,
  output logic                     op_ready,
  input  rcb_pkg::dp_status_t      status,
  output rcb_pkg::ctrl_cmd_t       cmd
);

  typedef enum logic [2:0] {
    IDLE  = 3'b001,
    QUERY = 3'b010,
    SCAN  = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    op_ready   = 1'b0;
    unique case (state)
      IDLE: begin
        op_ready = 1'b1;
        if (op_valid) begin
          cmd.accept = 1'b1;
          if (!status.skip && !status.halt_now) begin
            if (status.is_query) begin
              state_next = QUERY;
            end else begin
              cmd.start_scan = 1'b1;
              state_next     = SCAN;
            end
          end
        end
      end
      QUERY: begin
        if (status.out_free) begin
          cmd.load_query = 1'b1;
          state_next     = IDLE;
        end
      end
      SCAN: begin
        if (status.scan_done) begin
          state_next = IDLE;
        end else if (status.emit_now) begin
          // hold on this node until the output register can take it
          if (status.out_free) begin
            cmd.emit    = 1'b1;
            cmd.advance = 1'b1;
          end
        end else begin
          cmd.advance = 1'b1;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/rcb_datapath.sv
// ----------------------------------------------------------------------------
// rcb_datapath
// Counter state, failure mask, node walk and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rcb_datapath #(
  parameter int MAX_NODES = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  rcb_pkg::cfg_t            cfg,
  input  wire logic signed [31:0]  amount,
  input  rcb_pkg::ctrl_cmd_t       cmd,
  output rcb_pkg::dp_status_t      status,
  output rcb_pkg::result_t         result,
  output logic                     result_valid,
  input  wire logic                result_ready
);

  // node_count is 4 bits, so no more than 15 nodes are ever walked
  localparam int SCAN_N = (MAX_NODES < 15) ? MAX_NODES : 15;
  localparam int JW     = $clog2(SCAN_N + 1);
  localparam int IW     = $clog2(SCAN_N);

  logic [63:0]          running_total;
  logic [30:0]          ops_done;
  logic [MAX_NODES-1:0] failed_mask;
  logic                 halted;
  logic [JW-1:0]        j;
  logic [23:0]          qpn;
  logic [2:0]           cnt;

  logic [JW-1:0]        n;
  logic [SCAN_N-1:0]    peer, elig, after;
  logic [IW-1:0]        jidx;
  logic                 peer_now;
  logic                 more_after;
  logic                 fail_hit;
  logic [63:0]          amount_ext;
  logic [23:0]          qpn_start;
  logic [47:0]          remote_addr;

  always_comb begin
    n = (int'(cfg.node_count) > SCAN_N) ? JW'(SCAN_N) : JW'(cfg.node_count);
    for (int k = 0; k < SCAN_N; k++) begin
      peer[k]  = (JW'(k) < n) && (k != int'(cfg.board_id));
      elig[k]  = peer[k] && !failed_mask[k];
      after[k] = JW'(k) > j;
    end
    jidx        = j[IW-1:0];
    peer_now    = peer[jidx];
    more_after  = |(elig & after);
    fail_hit    = (ops_done == cfg.fail_at_op);
    amount_ext  = {{32{amount[31]}}, amount};
    qpn_start   = 24'(cfg.board_id) * 24'(n - JW'(1));
    remote_addr = cfg.remote_base + {43'd0, cfg.board_id, 2'b00};
  end

  always_comb begin
    status.skip      = halted || (ops_done >= cfg.op_total);
    status.halt_now  = fail_hit && (cfg.failing_node == cfg.board_id);
    status.is_query  = (amount == 32'sd0);
    status.out_free  = !result_valid || result_ready;
    status.scan_done = (j == n) || (cnt == 3'(rcb_pkg::MAX_OUT));
    status.emit_now  = elig[jidx];
    status.halted    = halted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_total <= '0;
      ops_done      <= '0;
      failed_mask   <= '0;
      halted        <= 1'b0;
      j             <= '0;
      qpn           <= '0;
      cnt           <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (cmd.accept && !status.skip) begin
        if (!status.is_query) begin
          running_total <= running_total + amount_ext;
        end
        if (fail_hit) begin
          // a failing node outside the mask marks nothing
          for (int k = 0; k < MAX_NODES; k++) begin
            if (k == int'(cfg.failing_node)) begin
              failed_mask[k] <= 1'b1;
            end
          end
        end
        if (status.halt_now) begin
          halted <= 1'b1;
        end else begin
          ops_done <= ops_done + 31'd1;
        end
      end

      if (cmd.start_scan) begin
        j   <= '0;
        qpn <= qpn_start;
        cnt <= '0;
      end else if (cmd.advance) begin
        j <= j + JW'(1);
        // queue numbers step over failed and skipped peers too
        if (peer_now) begin
          qpn <= qpn + 24'd1;
        end
        if (cmd.emit) begin
          cnt <= cnt + 3'd1;
        end
      end

      if (cmd.load_query || cmd.emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      result.kind            <= rcb_pkg::KIND_QUERY;
      result.queue_number    <= '0;
      result.local_addr_out  <= '0;
      result.remote_addr_out <= '0;
      result.length_out      <= '0;
      result.value           <= running_total;
      result.last            <= 1'b1;
    end else if (cmd.emit) begin
      result.kind            <= rcb_pkg::KIND_WRITE;
      result.queue_number    <= qpn;
      result.local_addr_out  <= cfg.local_address;
      result.remote_addr_out <= remote_addr;
      result.length_out      <= cfg.transfer_length;
      result.value           <= {{32{running_total[31]}}, running_total[31:0]};
      result.last            <= (cnt == 3'(rcb_pkg::MAX_OUT - 1)) || !more_after;
    end
  end

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the replicated counter broadcaster. Ops go in on a
// valid/ready channel while a predictor tracks the counter, the op count,
// the failed-node mask and the halt flag, and queues the query responses and
// write descriptors that each accepted op should produce. Every result taken
// from the output channel is checked field by field against the oldest
// expectation. Both channels are paced with random idles and stalls.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int GROUP_LIMIT    = 8;     // MAX_NODES of the instance
  localparam int SETTLE_CYCLES  = 24;    // longest walk plus output register
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  rcb_pkg::cfg_index_t cfg_index;
  logic [47:0]         cfg_data;

  rcb_op_if     op_ch();
  rcb_result_if res_ch();

  replicated_counter_broadcaster u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ops       (op_ch.sink),
    .results   (res_ch.source)
  );

  // predicted block state
  rcb_pkg::cfg_t cfg_model;
  logic [63:0]   counter_model;
  logic [30:0]   ops_count;
  logic [7:0]    dead_nodes;
  logic          halted_model;

  rcb_pkg::result_t pending_results[$];
  int      mismatch_count;
  int      idle_cycles;
  int      src_idle_pct;
  int      sink_stall_pct;
  logic    sink_hold;
  event    hold_ev;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------- predictor
  task automatic apply_counter_op(input logic signed [31:0] amt);
    logic [63:0]      delta;
    int               group;
    logic [23:0]      queue_no;
    logic [47:0]      raddr;
    logic [63:0]      wval;
    rcb_pkg::result_t r;
    rcb_pkg::result_t batch[$];
    delta = {{32{amt[31]}}, amt};
    if (halted_model || ops_count >= cfg_model.op_total) return;
    counter_model = counter_model + delta;
    if (ops_count == cfg_model.fail_at_op) begin
      dead_nodes[cfg_model.failing_node] = 1'b1;
      if (cfg_model.failing_node == cfg_model.board_id) begin
        halted_model = 1'b1;
        return;
      end
    end
    if (amt == 0) begin
      r       = '0;
      r.kind  = rcb_pkg::KIND_QUERY;
      r.value = counter_model;
      r.last  = 1'b1;
      pending_results.push_back(r);
      ops_count = ops_count + 31'd1;
      return;
    end
    group    = (cfg_model.node_count > GROUP_LIMIT) ? GROUP_LIMIT : cfg_model.node_count;
    queue_no = 24'(int'(cfg_model.board_id) * (group - 1));
    raddr    = cfg_model.remote_base + 48'({cfg_model.board_id, 2'b00});
    wval     = {{32{counter_model[31]}}, counter_model[31:0]};
    for (int j = 0; j < group; j++) begin
      if (j == cfg_model.board_id) continue;
      if (dead_nodes[j]) begin
        queue_no++;
        continue;
      end
      if (batch.size() < rcb_pkg::MAX_OUT) begin
        r.kind            = rcb_pkg::KIND_WRITE;
        r.queue_number    = queue_no;
        r.local_addr_out  = cfg_model.local_address;
        r.remote_addr_out = raddr;
        r.length_out      = cfg_model.transfer_length;
        r.value           = wval;
        r.last            = 1'b0;
        batch.push_back(r);
      end
      queue_no++;
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) pending_results.push_back(batch[k]);
    ops_count = ops_count + 31'd1;
  endtask

  // ---------------------------------------------------------------- drivers
  task automatic write_reg(input rcb_pkg::cfg_index_t idx, input logic [47:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      rcb_pkg::CFG_OP_TOTAL:        cfg_model.op_total        = data[30:0];
      rcb_pkg::CFG_NODE_COUNT:      cfg_model.node_count      = data[3:0];
      rcb_pkg::CFG_BOARD_ID:        cfg_model.board_id        = data[2:0];
      rcb_pkg::CFG_FAIL_AT_OP:      cfg_model.fail_at_op      = data[30:0];
      rcb_pkg::CFG_FAILING_NODE:    cfg_model.failing_node    = data[2:0];
      rcb_pkg::CFG_LOCAL_ADDRESS:   cfg_model.local_address   = data;
      rcb_pkg::CFG_REMOTE_BASE:     cfg_model.remote_base     = data;
      rcb_pkg::CFG_TRANSFER_LENGTH: cfg_model.transfer_length = data[31:0];
      default: ;
    endcase
  endtask

  task automatic send_op(input logic signed [31:0] amt);
    while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      op_ch.valid = 1'b0;
      @(negedge clk);
    end
    op_ch.amount = amt;
    op_ch.valid  = 1'b1;
    @(posedge clk);
    while (!op_ch.ready) @(posedge clk);
    apply_counter_op(amt);
    @(negedge clk);
  endtask

  // an op with no result may still be walking the node list
  task automatic wait_idle();
    op_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_group(input int nodes, input int board);
    write_reg(rcb_pkg::CFG_NODE_COUNT, 48'(nodes));
    write_reg(rcb_pkg::CFG_BOARD_ID, 48'(board));
  endtask

  function automatic logic signed [31:0] random_amount();
    case ($urandom_range(0, 9))
      0, 1:    return 32'sd0;
      2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      3:       return $urandom_range(0, 1) ? 32'($urandom_range(1, 16))
                                           : -32'($urandom_range(1, 16));
      default: return $urandom;
    endcase
  endfunction

  task automatic shuffle_group_setup();
    int nodes;
    nodes = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(2, 8);
    set_group(nodes, $urandom_range(0, 7));
    write_reg(rcb_pkg::CFG_LOCAL_ADDRESS, 48'({$urandom, $urandom}));
    if ($urandom_range(0, 3) == 0)
      write_reg(rcb_pkg::CFG_REMOTE_BASE, 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 40)));
    else
      write_reg(rcb_pkg::CFG_REMOTE_BASE, 48'({$urandom, $urandom}));
    write_reg(rcb_pkg::CFG_TRANSFER_LENGTH, 48'($urandom));
  endtask

  // ---------------------------------------------------------------- sink side
  initial begin
    sink_hold = 1'b0;
    forever begin
      @(hold_ev);
      sink_hold = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      sink_hold = 1'b0;
    end
  end

  always @(negedge clk) begin
    if (sink_hold) res_ch.ready <= 1'b0;
    else res_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  task automatic check_field(input string field, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    rcb_pkg::result_t got;
    rcb_pkg::result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = res_ch.data;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: 0x%0h", got);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 64'(want.kind), 64'(got.kind));
        check_field("queue_number", 64'(want.queue_number), 64'(got.queue_number));
        check_field("local_addr_out", 64'(want.local_addr_out), 64'(got.local_addr_out));
        check_field("remote_addr_out", 64'(want.remote_addr_out), 64'(got.remote_addr_out));
        check_field("length_out", 64'(want.length_out), 64'(got.length_out));
        check_field("value", want.value, got.value);
        check_field("last", 64'(want.last), 64'(got.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_reset_defaults();
    // op budget is zero out of reset: everything is dropped
    send_op(32'sd0);
    send_op(32'sd5);
    send_op(-32'sd3);
    wait_idle();
    write_reg(rcb_pkg::CFG_OP_TOTAL, 48'h7FFF_FFFF);
    send_op(32'sd0);
    send_op(32'sd1);
    send_op(-32'sd1);
  endtask

  task automatic test_directed_ops();
    wait_idle();
    set_group(8, 7);
    write_reg(rcb_pkg::CFG_LOCAL_ADDRESS, 48'hFFFF_FFFF_FFFF);
    write_reg(rcb_pkg::CFG_REMOTE_BASE, 48'hFFFF_FFFF_FFFF);   // wraps past 2^48
    write_reg(rcb_pkg::CFG_TRANSFER_LENGTH, 48'hFFFF_FFFF);
    send_op(32'sh7FFF_FFFF);
    send_op(32'sh8000_0000);
    send_op(32'sd0);
    send_op(-32'sd1);
    wait_idle();
    set_group(8, 0);
    write_reg(rcb_pkg::CFG_LOCAL_ADDRESS, 48'h0);
    write_reg(rcb_pkg::CFG_REMOTE_BASE, 48'h0);
    write_reg(rcb_pkg::CFG_TRANSFER_LENGTH, 48'h0);
    send_op(32'sd1);
    send_op(32'sd0);
    // empty group: increments give nothing, queries still answer
    wait_idle();
    set_group(0, 0);
    send_op(32'sd5);
    send_op(32'sd0);
    wait_idle();
    set_group(1, 0);
    send_op(32'sd3);
    wait_idle();
    set_group(1, 1);
    send_op(32'sd2);
    // oversized group is clamped
    wait_idle();
    set_group(15, 3);
    send_op(-32'sd7);
    // board outside the group: every node is a peer
    wait_idle();
    set_group(4, 6);
    send_op(32'sd11);
  endtask

  task automatic test_random_traffic();
    int idle_plan[4];
    int stall_plan[4];
    idle_plan  = '{0, 46, 0, 27};
    stall_plan = '{0, 0, 46, 27};
    for (int phase = 0; phase < 4; phase++) begin
      src_idle_pct   = idle_plan[phase];
      sink_stall_pct = stall_plan[phase];
      for (int seg = 0; seg < 4; seg++) begin
        wait_idle();
        shuffle_group_setup();
        repeat (25) send_op(random_amount());
      end
    end
    src_idle_pct   = 0;
    sink_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    wait_idle();
    set_group(8, 1);
    -> hold_ev;
    repeat (25) send_op(random_amount() | 32'sd1);
    src_idle_pct   = 27;
    sink_stall_pct = 27;
  endtask

  task automatic test_op_budget();
    wait_idle();
    write_reg(rcb_pkg::CFG_FAIL_AT_OP, 48'h0);   // already passed, must not fire
    set_group(3, 1);
    write_reg(rcb_pkg::CFG_OP_TOTAL, 48'(ops_count + 31'd3));
    send_op(32'sd0);
    send_op(32'sd4);
    send_op(-32'sd4);
    send_op(32'sd0);
    send_op(32'sd8);
    wait_idle();
    write_reg(rcb_pkg::CFG_OP_TOTAL, 48'h0);
    send_op(32'sd0);
    send_op(32'sd6);
    wait_idle();
    write_reg(rcb_pkg::CFG_OP_TOTAL, 48'h7FFF_FFFF);
    send_op(32'sd0);
    send_op(32'sd6);
  endtask

  task automatic test_failure_injection();
    wait_idle();
    set_group(8, 2);
    write_reg(rcb_pkg::CFG_FAILING_NODE, 48'd5);
    write_reg(rcb_pkg::CFG_FAIL_AT_OP, 48'(ops_count + 31'd2));
    repeat (4) send_op(random_amount() | 32'sd1);
    wait_idle();
    write_reg(rcb_pkg::CFG_FAILING_NODE, 48'd0);
    write_reg(rcb_pkg::CFG_FAIL_AT_OP, 48'(ops_count + 31'd1));
    send_op(32'sd0);
    send_op(32'sd9);
    send_op(32'sd0);   // failure lands on the op before this query
    send_op(-32'sd9);
    wait_idle();
    set_group(4, 6);
    send_op(32'sd2);
    send_op(32'sd0);
    // failed node outside the current group
    wait_idle();
    set_group(4, 1);
    write_reg(rcb_pkg::CFG_FAILING_NODE, 48'd6);
    write_reg(rcb_pkg::CFG_FAIL_AT_OP, 48'(ops_count));
    send_op(32'sd3);
    send_op(32'sd1);
    wait_idle();
    set_group(8, 3);
    repeat (3) send_op(random_amount());
    // the only peer is failed: increments give nothing
    wait_idle();
    set_group(2, 1);
    send_op(32'sd12);
    send_op(32'sd0);
    send_op(-32'sd12);
  endtask

  task automatic test_board_halt();
    wait_idle();
    set_group(8, 4);
    write_reg(rcb_pkg::CFG_FAILING_NODE, 48'd4);
    write_reg(rcb_pkg::CFG_FAIL_AT_OP, 48'(ops_count + 31'd2));
    send_op(32'sd1);
    send_op(32'sd0);
    send_op(32'sd5);   // halts here
    send_op(32'sd0);
    send_op(32'sd7);
    send_op(32'sd0);
  endtask

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = rcb_pkg::CFG_OP_TOTAL;
    cfg_data       = '0;
    op_ch.valid    = 1'b0;
    op_ch.amount   = '0;
    res_ch.ready   = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    mismatch_count = 0;
    idle_cycles    = 0;
    counter_model  = '0;
    ops_count      = '0;
    dead_nodes     = '0;
    halted_model   = 1'b0;
    cfg_model                 = '0;
    cfg_model.node_count      = rcb_pkg::NODE_COUNT_RST;
    cfg_model.fail_at_op      = rcb_pkg::FAIL_AT_OP_RST;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_directed_ops();
    test_random_traffic();
    test_backpressure();
    test_op_budget();
    test_failure_injection();
    test_board_halt();

    op_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (2 * SETTLE_CYCLES) @(negedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
